/* hw/rtl/lffs_pkg.sv */
// ----------------------------------------------------------------------------
// lffs_pkg
// Shared types and constants of the link frame filter and failsafe unit.
// ----------------------------------------------------------------------------
package lffs_pkg;

  localparam int ADDR_W   = 48;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 32;
  localparam int TMO_W    = 16;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TMO_W-1:0]  tmo_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // input commands
  localparam cmd_t CMD_FRAME = 2'd0;
  localparam cmd_t CMD_TICK  = 2'd1;
  localparam cmd_t CMD_STEP  = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t CFG_PAD_ADDRESS  = 3'd0;
  localparam cfg_idx_t CFG_PROTO_VER    = 3'd1;
  localparam cfg_idx_t CFG_CTRL_TYPE    = 3'd2;
  localparam cfg_idx_t CFG_HELLO_TYPE   = 3'd3;
  localparam cfg_idx_t CFG_PEER_ROLE    = 3'd4;
  localparam cfg_idx_t CFG_LINK_TIMEOUT = 3'd5;
  localparam cfg_idx_t CFG_TELEM_DIV    = 3'd6;

  // a hello shorter than this carries no version byte
  localparam byte_t HELLO_MIN_VER_LEN = 8'd2;

  // depth of the queue between classifier and executor
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    addr_t pad_address;
    byte_t protocol_version;
    byte_t control_type_code;
    byte_t hello_type_code;
    byte_t peer_role_code;
    tmo_t  link_timeout_ms;
    byte_t telemetry_divider;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FOREIGN,
    OP_CONTROL,
    OP_HELLO,
    OP_ERROR,
    OP_TICK,
    OP_STEP
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    addr_t    addr;      // sender address of a foreign frame
    byte_t    ver;       // version byte of a hello
    logic     ver_wr;    // hello long enough to carry a version
    logic     agree;     // hello version matches ours
    logic     bad;       // hello of wrong length or role
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic  link_alive;
    logic  failsafe_active;
    logic  cut_drive;
    logic  link_restored;
    logic  capture_control;
    logic  wake_telemetry;
    logic  version_agreed;
    byte_t peer_version;
    logic  protocol_error_seen;
    cnt_t  foreign_frames;
    cnt_t  protocol_errors;
    addr_t last_foreign_address;
  } res_t;

endpackage

/* hw/rtl/lffs_if.sv */
// ----------------------------------------------------------------------------
// lffs channel interfaces
// Valid/ready channels for frame items, results and configuration writes.
// ----------------------------------------------------------------------------
interface lffs_in_if
  import lffs_pkg::*;
();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  logic  sender_present;
  addr_t sender_address;
  byte_t frame_length;
  byte_t type_byte;
  byte_t version_byte;
  byte_t role_byte;

  modport source (
    output valid, cmd, sender_present, sender_address, frame_length,
           type_byte, version_byte, role_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, sender_present, sender_address, frame_length,
           type_byte, version_byte, role_byte,
    output ready
  );
endinterface

interface lffs_out_if
  import lffs_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  link_alive;
  logic  failsafe_active;
  logic  cut_drive;
  logic  link_restored;
  logic  capture_control;
  logic  wake_telemetry;
  logic  version_agreed;
  byte_t peer_version;
  logic  protocol_error_seen;
  cnt_t  foreign_frames;
  cnt_t  protocol_errors;
  addr_t last_foreign_address;

  modport source (
    output valid, link_alive, failsafe_active, cut_drive, link_restored,
           capture_control, wake_telemetry, version_agreed, peer_version,
           protocol_error_seen, foreign_frames, protocol_errors,
           last_foreign_address,
    input  ready
  );
  modport sink (
    input  valid, link_alive, failsafe_active, cut_drive, link_restored,
           capture_control, wake_telemetry, version_agreed, peer_version,
           protocol_error_seen, foreign_frames, protocol_errors,
           last_foreign_address,
    output ready
  );
endinterface

interface lffs_cfg_if
  import lffs_pkg::*;
();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  addr_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/lffs_cfg.sv */
// ----------------------------------------------------------------------------
// lffs_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module lffs_cfg
  import lffs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lffs_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PAD_ADDRESS:  cfg_nxt.pad_address       = cfg_ch.data;
        CFG_PROTO_VER:    cfg_nxt.protocol_version  = cfg_ch.data[BYTE_W-1:0];
        CFG_CTRL_TYPE:    cfg_nxt.control_type_code = cfg_ch.data[BYTE_W-1:0];
        CFG_HELLO_TYPE:   cfg_nxt.hello_type_code   = cfg_ch.data[BYTE_W-1:0];
        CFG_PEER_ROLE:    cfg_nxt.peer_role_code    = cfg_ch.data[BYTE_W-1:0];
        CFG_LINK_TIMEOUT: cfg_nxt.link_timeout_ms   = cfg_ch.data[TMO_W-1:0];
        CFG_TELEM_DIV:    cfg_nxt.telemetry_divider = cfg_ch.data[BYTE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pad_address       <= '0;
      cfg_r.protocol_version  <= 8'd4;
      cfg_r.control_type_code <= 8'd1;
      cfg_r.hello_type_code   <= 8'd2;
      cfg_r.peer_role_code    <= 8'd1;
      cfg_r.link_timeout_ms   <= 16'd500;
      cfg_r.telemetry_divider <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/lffs_front.sv */
// ----------------------------------------------------------------------------
// lffs_front
// Accepts input transactions and classifies each into an operation.
// ----------------------------------------------------------------------------
module lffs_front
  import lffs_pkg::*;
#(
  parameter int CONTROL_FRAME_LEN = 16,
  parameter int HELLO_FRAME_LEN   = 8
) (
  input  cfg_t        cfg,
  lffs_in_if.sink     in_ch,
  input  q_stat_t     q_stat,
  output logic        push,
  output op_t         push_op
);

  localparam byte_t CTRL_LEN  = BYTE_W'(CONTROL_FRAME_LEN);
  localparam byte_t HELLO_LEN = BYTE_W'(HELLO_FRAME_LEN);

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_op        = '0;
    push_op.kind   = OP_NONE;
    push_op.addr   = in_ch.sender_address;
    push_op.ver    = in_ch.version_byte;
    push_op.ver_wr = in_ch.frame_length >= HELLO_MIN_VER_LEN;
    push_op.agree  = in_ch.version_byte == cfg.protocol_version;
    push_op.bad    = (in_ch.frame_length != HELLO_LEN) ||
                     (in_ch.role_byte != cfg.peer_role_code);
    unique case (in_ch.cmd)
      CMD_FRAME: begin
        priority if (!in_ch.sender_present) begin
          push_op.kind = OP_NONE;
        end else if (in_ch.sender_address != cfg.pad_address) begin
          push_op.kind = OP_FOREIGN;
        end else if (in_ch.frame_length == '0) begin
          push_op.kind = OP_NONE;
        end else if (in_ch.type_byte == cfg.control_type_code) begin
          push_op.kind = (in_ch.frame_length == CTRL_LEN) ? OP_CONTROL : OP_ERROR;
        end else if (in_ch.type_byte == cfg.hello_type_code) begin
          push_op.kind = OP_HELLO;
        end else begin
          push_op.kind = OP_ERROR;
        end
      end
      CMD_TICK: push_op.kind = OP_TICK;
      CMD_STEP: push_op.kind = OP_STEP;
      default:  push_op.kind = OP_NONE;
    endcase
  end

endmodule

/* hw/rtl/lffs_queue.sv */
// ----------------------------------------------------------------------------
// lffs_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module lffs_queue
  import lffs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head_op,
  output q_stat_t q_stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(Q_DEPTH - 1);

  op_t                slot_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;

  assign head_op      = slot_r[rd_ptr_r];
  assign q_stat.valid = count_r != '0;
  assign q_stat.full  = count_r == CNT_QW'(Q_DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* hw/rtl/lffs_back.sv */
// ----------------------------------------------------------------------------
// lffs_back
// Executes queued operations on the link state and registers each result.
// ----------------------------------------------------------------------------
module lffs_back
  import lffs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  q_stat_t     q_stat,
  input  op_t         head_op,
  output logic        pop,
  lffs_out_if.source  out_ch
);

  cnt_t  now_r, now_nxt;
  cnt_t  last_r, last_nxt;
  logic  peer_seen_r, peer_seen_nxt;
  logic  agreed_r, agreed_nxt;
  byte_t peer_ver_r, peer_ver_nxt;
  logic  latch_r, latch_nxt;
  logic  alive_r, alive_nxt;
  byte_t phase_r, phase_nxt;
  cnt_t  foreign_r, foreign_nxt;
  cnt_t  err_r, err_nxt;
  addr_t faddr_r, faddr_nxt;

  logic  out_valid_r;
  res_t  res_r, res_nxt;

  cnt_t              gap;
  logic              alive_now;
  byte_t             div;
  logic [BYTE_W:0]   phase_inc;

  // the output register frees up when empty or being taken this cycle
  assign pop = q_stat.valid && (!out_valid_r || out_ch.ready);

  assign gap       = now_r - last_r;
  assign alive_now = peer_seen_r && agreed_r && (gap < CNT_W'(cfg.link_timeout_ms));
  assign div       = (cfg.telemetry_divider == '0) ? BYTE_W'(1) : cfg.telemetry_divider;
  assign phase_inc = {1'b0, phase_r} + 1'b1;

  always_comb begin
    now_nxt       = now_r;
    last_nxt      = last_r;
    peer_seen_nxt = peer_seen_r;
    agreed_nxt    = agreed_r;
    peer_ver_nxt  = peer_ver_r;
    latch_nxt     = latch_r;
    alive_nxt     = alive_r;
    phase_nxt     = phase_r;
    foreign_nxt   = foreign_r;
    err_nxt       = err_r;
    faddr_nxt     = faddr_r;
    res_nxt       = '0;

    unique case (head_op.kind)
      OP_NONE: ;
      OP_FOREIGN: begin
        faddr_nxt   = head_op.addr;
        foreign_nxt = foreign_r + 1'b1;
      end
      OP_CONTROL: begin
        res_nxt.capture_control = 1'b1;
        last_nxt      = now_r;
        peer_seen_nxt = 1'b1;
        if (phase_inc >= {1'b0, div}) begin
          phase_nxt              = '0;
          res_nxt.wake_telemetry = 1'b1;
        end else begin
          phase_nxt = phase_inc[BYTE_W-1:0];
        end
      end
      OP_HELLO: begin
        if (head_op.ver_wr) begin
          peer_ver_nxt = head_op.ver;
          agreed_nxt   = head_op.agree;
        end
        if (head_op.bad) begin
          err_nxt = err_r + 1'b1;
        end
      end
      OP_ERROR: err_nxt = err_r + 1'b1;
      OP_TICK:  now_nxt = now_r + 1'b1;
      OP_STEP: begin
        alive_nxt = alive_now;
        if (alive_now && latch_r) begin
          latch_nxt             = 1'b0;
          res_nxt.link_restored = 1'b1;
        end else if (!alive_now && !latch_r) begin
          latch_nxt         = 1'b1;
          res_nxt.cut_drive = 1'b1;
        end
      end
      default: ;
    endcase

    res_nxt.link_alive           = alive_nxt;
    res_nxt.failsafe_active      = latch_nxt;
    res_nxt.version_agreed       = agreed_nxt;
    res_nxt.peer_version         = peer_ver_nxt;
    res_nxt.protocol_error_seen  = err_nxt != '0;
    res_nxt.foreign_frames       = foreign_nxt;
    res_nxt.protocol_errors      = err_nxt;
    res_nxt.last_foreign_address = faddr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      last_r      <= '0;
      peer_seen_r <= 1'b0;
      agreed_r    <= 1'b0;
      peer_ver_r  <= '0;
      latch_r     <= 1'b0;
      alive_r     <= 1'b0;
      phase_r     <= '0;
      foreign_r   <= '0;
      err_r       <= '0;
      faddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        now_r       <= now_nxt;
        last_r      <= last_nxt;
        peer_seen_r <= peer_seen_nxt;
        agreed_r    <= agreed_nxt;
        peer_ver_r  <= peer_ver_nxt;
        latch_r     <= latch_nxt;
        alive_r     <= alive_nxt;
        phase_r     <= phase_nxt;
        foreign_r   <= foreign_nxt;
        err_r       <= err_nxt;
        faddr_r     <= faddr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.link_alive           = res_r.link_alive;
  assign out_ch.failsafe_active      = res_r.failsafe_active;
  assign out_ch.cut_drive            = res_r.cut_drive;
  assign out_ch.link_restored        = res_r.link_restored;
  assign out_ch.capture_control      = res_r.capture_control;
  assign out_ch.wake_telemetry       = res_r.wake_telemetry;
  assign out_ch.version_agreed       = res_r.version_agreed;
  assign out_ch.peer_version         = res_r.peer_version;
  assign out_ch.protocol_error_seen  = res_r.protocol_error_seen;
  assign out_ch.foreign_frames       = res_r.foreign_frames;
  assign out_ch.protocol_errors      = res_r.protocol_errors;
  assign out_ch.last_foreign_address = res_r.last_foreign_address;

endmodule

/* hw/rtl/link_frame_filter_failsafe_unit.sv */
// ----------------------------------------------------------------------------
// link_frame_filter_failsafe_unit
// Radio frame header filter and link failsafe supervisor, top level.
// ----------------------------------------------------------------------------
// Every input transaction (frame header, millisecond tick or control step)
// yields exactly one result transaction, in order. The unit takes one
// transaction per clock cycle unless the output stalls; an accepted input is
// queued, and its result is then registered in the output register. The
// classifier feeds a two-entry queue, and the executor drains it into a
// single output register, so input stays ready until that queue fills behind
// a stalled output. Configuration writes take effect on the next cycle; the
// user must make them only while the unit is idle; the unit does not check.
module link_frame_filter_failsafe_unit
  import lffs_pkg::*;
#(
  parameter int CONTROL_FRAME_LEN = 16,
  parameter int HELLO_FRAME_LEN   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  lffs_in_if.sink     in_ch,
  lffs_out_if.source  out_ch,
  lffs_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     head_op;

  lffs_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lffs_front #(
    .CONTROL_FRAME_LEN (CONTROL_FRAME_LEN),
    .HELLO_FRAME_LEN   (HELLO_FRAME_LEN)
  ) u_front (
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  lffs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  lffs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .head_op (head_op),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // executor never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // a drive cut leaves the failsafe engaged
  a_cut_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cut_drive) |-> out_ch.failsafe_active)
    else $error("cut_drive without failsafe");

  // a restore only happens on a live link with the latch released
  a_restore_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.link_restored) |->
      (out_ch.link_alive && !out_ch.failsafe_active && !out_ch.cut_drive))
    else $error("link_restored on dead link");

  // a transaction accepted with an empty queue reaches the executor next cycle
  a_queue_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_stat.valid) |=> q_stat.valid)
    else $error("queued transaction lost");
`endif

endmodule

/* sim/link_frame_filter_failsafe_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_frame_filter_failsafe_unit_tb
// Self-checking bench for the link frame filter and failsafe unit. A short
// table covers the reset state, field extremes and every frame class. Random
// phases follow under several register settings, including the extremes. The
// input side sends in bursts and the result side stalls on its own pattern.
// A bench model or a table row predicts each result, checked field by field.
// ----------------------------------------------------------------------------
module link_frame_filter_failsafe_unit_tb;
  import lffs_pkg::*;

  localparam int CONTROL_LEN     = 16;
  localparam int HELLO_LEN       = 8;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 40;

  localparam cmd_t  CMD_UNUSED     = 2'd3;
  localparam byte_t DEF_PROTO_VER  = 8'd4;
  localparam byte_t DEF_CTRL_TYPE  = 8'd1;
  localparam byte_t DEF_HELLO_TYPE = 8'd2;
  localparam byte_t DEF_PEER_ROLE  = 8'd1;
  localparam tmo_t  DEF_TIMEOUT    = 16'd500;
  localparam byte_t DEF_TELEM_DIV  = 8'd1;
  localparam byte_t UNKNOWN_TYPE   = 8'hFF;
  localparam addr_t ALL_ONES_ADDR  = '1;

  typedef struct packed {
    cmd_t  cmd;
    logic  sender_present;
    addr_t sender_address;
    byte_t frame_length;
    byte_t type_byte;
    byte_t version_byte;
    byte_t role_byte;
  } link_item_t;

  typedef struct packed {
    link_item_t it;
    logic       typed;
    res_t       want;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_pattern_t;

  logic clk;
  logic rst_n;

  lffs_in_if  in_ch ();
  lffs_out_if out_ch ();
  lffs_cfg_if cfg_ch ();

  link_frame_filter_failsafe_unit #(
    .CONTROL_FRAME_LEN(CONTROL_LEN),
    .HELLO_FRAME_LEN  (HELLO_LEN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // model state
  cfg_t  regs_m;
  cnt_t  ms_now;
  cnt_t  ms_last_ctrl;
  logic  pad_heard;
  logic  ver_ok;
  logic  drive_cut;
  logic  link_up;
  byte_t peer_ver;
  byte_t ctrl_phase;
  cnt_t  foreign_cnt;
  cnt_t  err_cnt;
  addr_t foreign_addr;

  res_t link_status_due[$];
  dir_row_t dir_rows[$];

  // typed expectation travels with the transaction it belongs to
  logic drv_typed;
  res_t drv_want;

  res_t predicted;
  res_t observed;
  res_t want;

  int unsigned mismatches    = 0;
  int unsigned items_in      = 0;
  int unsigned results_out   = 0;
  int unsigned settings_done = 0;
  int unsigned cuts_seen     = 0;
  int unsigned restores_seen = 0;
  int unsigned captures_seen = 0;
  int unsigned wakes_seen    = 0;
  int unsigned quiet_cycles  = 0;

  rx_pattern_t rx_pattern = RX_OPEN;
  logic [7:0]  rx_tick    = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               results_out, what, got, exp_val);
  endtask

  function automatic link_item_t frame_item(input cmd_t cmd, input logic present,
                                            input addr_t addr, input byte_t len,
                                            input byte_t typ, input byte_t ver,
                                            input byte_t role);
    link_item_t it;
    it = {cmd, present, addr, len, typ, ver, role};
    return it;
  endfunction

  // status while no hello has been heard: only the latch and counters move
  function automatic res_t early_status(input logic fs, input logic cut, input cnt_t fcnt,
                                        input cnt_t ecnt, input addr_t faddr);
    res_t r;
    r = '0;
    r.failsafe_active      = fs;
    r.cut_drive            = cut;
    r.protocol_error_seen  = (ecnt != 0);
    r.foreign_frames       = fcnt;
    r.protocol_errors      = ecnt;
    r.last_foreign_address = faddr;
    return r;
  endfunction

  function automatic res_t supervise_link(input link_item_t it);
    res_t       r;
    logic       bad;
    logic [8:0] nxt;
    logic [8:0] div;
    r   = '0;
    bad = 1'b0;
    case (it.cmd)
      CMD_FRAME: begin
        if (!it.sender_present) begin
          // anonymous frame, dropped
        end else if (it.sender_address != regs_m.pad_address) begin
          foreign_addr = it.sender_address;
          foreign_cnt  = foreign_cnt + 1;
        end else if (it.frame_length != 0) begin
          // control code wins when both type codes are equal
          if (it.type_byte == regs_m.control_type_code) begin
            if (it.frame_length == CONTROL_LEN) begin
              div = (regs_m.telemetry_divider == 0) ? 9'd1
                                                    : {1'b0, regs_m.telemetry_divider};
              nxt = {1'b0, ctrl_phase} + 9'd1;
              r.capture_control = 1'b1;
              ms_last_ctrl      = ms_now;
              pad_heard         = 1'b1;
              if (nxt >= div) begin
                nxt              = '0;
                r.wake_telemetry = 1'b1;
              end
              ctrl_phase = nxt[7:0];
            end else begin
              bad = 1'b1;
            end
          end else if (it.type_byte == regs_m.hello_type_code) begin
            if (it.frame_length >= HELLO_MIN_VER_LEN) begin
              peer_ver = it.version_byte;
              ver_ok   = (it.version_byte == regs_m.protocol_version);
            end
            bad = (it.frame_length != HELLO_LEN) || (it.role_byte != regs_m.peer_role_code);
          end else begin
            bad = 1'b1;
          end
          if (bad)
            err_cnt = err_cnt + 1;
        end
      end
      CMD_TICK: begin
        ms_now = ms_now + 1;
      end
      CMD_STEP: begin
        // wrapping gap; a zero timeout never passes
        link_up = pad_heard && ver_ok &&
                  ((ms_now - ms_last_ctrl) < cnt_t'(regs_m.link_timeout_ms));
        if (link_up && drive_cut) begin
          drive_cut       = 1'b0;
          r.link_restored = 1'b1;
        end else if (!link_up && !drive_cut) begin
          drive_cut   = 1'b1;
          r.cut_drive = 1'b1;
        end
      end
      default: begin
        // unused command: status only
      end
    endcase
    r.link_alive           = link_up;
    r.failsafe_active      = drive_cut;
    r.version_agreed       = ver_ok;
    r.peer_version         = peer_ver;
    r.protocol_error_seen  = (err_cnt != 0);
    r.foreign_frames       = foreign_cnt;
    r.protocol_errors      = err_cnt;
    r.last_foreign_address = foreign_addr;
    return r;
  endfunction

  task automatic send_item(input link_item_t it, input logic typed, input res_t exp_res);
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= it.cmd;
    in_ch.sender_present <= it.sender_present;
    in_ch.sender_address <= it.sender_address;
    in_ch.frame_length   <= it.frame_length;
    in_ch.type_byte      <= it.type_byte;
    in_ch.version_byte   <= it.version_byte;
    in_ch.role_byte      <= it.role_byte;
    drv_typed            <= typed;
    drv_want             <= exp_res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // narrow registers get random junk above their width
  task automatic put_reg(input cfg_idx_t idx, input addr_t val, input int w);
    addr_t junk;
    junk = addr_t'({$urandom, $urandom}) << w;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= junk | val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic settle();
    do @(negedge clk); while (link_status_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // model update and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      regs_m.pad_address       = '0;
      regs_m.protocol_version  = DEF_PROTO_VER;
      regs_m.control_type_code = DEF_CTRL_TYPE;
      regs_m.hello_type_code   = DEF_HELLO_TYPE;
      regs_m.peer_role_code    = DEF_PEER_ROLE;
      regs_m.link_timeout_ms   = DEF_TIMEOUT;
      regs_m.telemetry_divider = DEF_TELEM_DIV;
      ms_now       = '0;
      ms_last_ctrl = '0;
      pad_heard    = 1'b0;
      ver_ok       = 1'b0;
      drive_cut    = 1'b0;
      link_up      = 1'b0;
      peer_ver     = '0;
      ctrl_phase   = '0;
      foreign_cnt  = '0;
      err_cnt      = '0;
      foreign_addr = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_PAD_ADDRESS:  regs_m.pad_address       = cfg_ch.data;
          CFG_PROTO_VER:    regs_m.protocol_version  = cfg_ch.data[7:0];
          CFG_CTRL_TYPE:    regs_m.control_type_code = cfg_ch.data[7:0];
          CFG_HELLO_TYPE:   regs_m.hello_type_code   = cfg_ch.data[7:0];
          CFG_PEER_ROLE:    regs_m.peer_role_code    = cfg_ch.data[7:0];
          CFG_LINK_TIMEOUT: regs_m.link_timeout_ms   = cfg_ch.data[15:0];
          CFG_TELEM_DIV:    regs_m.telemetry_divider = cfg_ch.data[7:0];
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = supervise_link({in_ch.cmd, in_ch.sender_present, in_ch.sender_address,
                                    in_ch.frame_length, in_ch.type_byte,
                                    in_ch.version_byte, in_ch.role_byte});
        link_status_due.push_back(drv_typed ? drv_want : predicted);
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        observed = {out_ch.link_alive, out_ch.failsafe_active, out_ch.cut_drive,
                    out_ch.link_restored, out_ch.capture_control, out_ch.wake_telemetry,
                    out_ch.version_agreed, out_ch.peer_version, out_ch.protocol_error_seen,
                    out_ch.foreign_frames, out_ch.protocol_errors,
                    out_ch.last_foreign_address};
        results_out++;
        cuts_seen     += observed.cut_drive;
        restores_seen += observed.link_restored;
        captures_seen += observed.capture_control;
        wakes_seen    += observed.wake_telemetry;
        if (link_status_due.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          want = link_status_due.pop_front();
          if (observed.link_alive !== want.link_alive)
            report_mismatch("link_alive", observed.link_alive, want.link_alive);
          if (observed.failsafe_active !== want.failsafe_active)
            report_mismatch("failsafe_active", observed.failsafe_active,
                            want.failsafe_active);
          if (observed.cut_drive !== want.cut_drive)
            report_mismatch("cut_drive", observed.cut_drive, want.cut_drive);
          if (observed.link_restored !== want.link_restored)
            report_mismatch("link_restored", observed.link_restored, want.link_restored);
          if (observed.capture_control !== want.capture_control)
            report_mismatch("capture_control", observed.capture_control,
                            want.capture_control);
          if (observed.wake_telemetry !== want.wake_telemetry)
            report_mismatch("wake_telemetry", observed.wake_telemetry, want.wake_telemetry);
          if (observed.version_agreed !== want.version_agreed)
            report_mismatch("version_agreed", observed.version_agreed, want.version_agreed);
          if (observed.peer_version !== want.peer_version)
            report_mismatch("peer_version", observed.peer_version, want.peer_version);
          if (observed.protocol_error_seen !== want.protocol_error_seen)
            report_mismatch("protocol_error_seen", observed.protocol_error_seen,
                            want.protocol_error_seen);
          if (observed.foreign_frames !== want.foreign_frames)
            report_mismatch("foreign_frames", observed.foreign_frames, want.foreign_frames);
          if (observed.protocol_errors !== want.protocol_errors)
            report_mismatch("protocol_errors", observed.protocol_errors,
                            want.protocol_errors);
          if (observed.last_foreign_address !== want.last_foreign_address)
            report_mismatch("last_foreign_address", observed.last_foreign_address,
                            want.last_foreign_address);
        end
      end
    end
  end

  // result side backpressure, pattern redrawn whenever rx_tick[6:0] is zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[6:0] == 7'd0)
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= (rx_tick[2:0] == 3'd0);
      default:   out_ch.ready <= rx_tick[4];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, link_status_due.size());
      $display("link_frame_filter_failsafe_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t        s;
    link_item_t  it;
    int unsigned burst_left;
    int unsigned idle_gap;
    int unsigned r;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_FRAME;
    in_ch.sender_present <= 1'b0;
    in_ch.sender_address <= '0;
    in_ch.frame_length   <= '0;
    in_ch.type_byte      <= '0;
    in_ch.version_byte   <= '0;
    in_ch.role_byte      <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_PAD_ADDRESS;
    cfg_ch.data          <= '0;
    drv_typed            <= 1'b0;
    drv_want             <= '0;

    // directed table, run under the reset register values
    // fresh from reset nothing has been heard, so the first step cuts the drive
    dir_rows.push_back('{frame_item(CMD_STEP, 1'b0, '0, 8'd0, 8'd0, 8'd0, 8'd0),
                         1'b1, early_status(1'b1, 1'b1, 32'd0, 32'd0, '0)});
    // anonymous frame is dropped
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b0, ALL_ONES_ADDR, byte_t'(CONTROL_LEN),
                                    DEF_CTRL_TYPE, 8'hFF, 8'hFF),
                         1'b1, early_status(1'b1, 1'b0, 32'd0, 32'd0, '0)});
    // foreign sender at the top of the address space
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, ALL_ONES_ADDR, 8'hFF,
                                    UNKNOWN_TYPE, 8'hFF, 8'hFF),
                         1'b1, early_status(1'b1, 1'b0, 32'd1, 32'd0, ALL_ONES_ADDR)});
    // empty frame from the pad
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, 8'd0, DEF_CTRL_TYPE, 8'd0, 8'd0),
                         1'b1, early_status(1'b1, 1'b0, 32'd1, 32'd0, ALL_ONES_ADDR)});
    // unknown type at the longest length
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, 8'hFF, UNKNOWN_TYPE, 8'd0, 8'd0),
                         1'b1, early_status(1'b1, 1'b0, 32'd1, 32'd1, ALL_ONES_ADDR)});
    // hello of wrong length still records the version
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(CONTROL_LEN), DEF_HELLO_TYPE,
                                    DEF_PROTO_VER, DEF_PEER_ROLE), 1'b0, '0});
    // hello too short to carry a version
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, 8'd1, DEF_HELLO_TYPE,
                                    8'hAA, DEF_PEER_ROLE), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(HELLO_LEN), DEF_HELLO_TYPE,
                                    DEF_PROTO_VER, DEF_PEER_ROLE), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(CONTROL_LEN), DEF_CTRL_TYPE,
                                    8'd0, 8'd0), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_STEP, 1'b0, '0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(CONTROL_LEN - 1),
                                    DEF_CTRL_TYPE, 8'd0, 8'd0), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(CONTROL_LEN + 1),
                                    DEF_CTRL_TYPE, 8'd0, 8'd0), 1'b0, '0});
    // shortest hello with a version, foreign version and wrong role
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, HELLO_MIN_VER_LEN, DEF_HELLO_TYPE,
                                    8'hFF, 8'h00), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_STEP, 1'b0, '0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0});
    // agreeing hello with a wrong role
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, '0, byte_t'(HELLO_LEN), DEF_HELLO_TYPE,
                                    DEF_PROTO_VER, 8'hFF), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_STEP, 1'b0, '0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_UNUSED, 1'b1, ALL_ONES_ADDR, 8'hFF, 8'hFF,
                                    8'hFF, 8'hFF), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_TICK, 1'b1, ALL_ONES_ADDR, 8'hFF, 8'hFF,
                                    8'hFF, 8'hFF), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_FRAME, 1'b1, 48'd1, byte_t'(CONTROL_LEN),
                                    DEF_CTRL_TYPE, 8'd0, 8'd0), 1'b0, '0});
    dir_rows.push_back('{frame_item(CMD_STEP, 1'b0, '0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      s.pad_address       = addr_t'({$urandom, $urandom});
      s.protocol_version  = byte_t'($urandom);
      s.control_type_code = byte_t'($urandom);
      s.hello_type_code   = s.control_type_code + byte_t'($urandom_range(1, 255));
      s.peer_role_code    = byte_t'($urandom);
      s.link_timeout_ms   = tmo_t'($urandom_range(1, 12));
      s.telemetry_divider = byte_t'($urandom_range(1, 8));
      case (p)
        0: begin
          s.pad_address       = '0;
          s.protocol_version  = 8'h00;
          s.control_type_code = 8'h00;
          s.hello_type_code   = 8'h01;
          s.peer_role_code    = 8'h00;
          s.link_timeout_ms   = 16'd1;
          s.telemetry_divider = 8'd1;
        end
        1: begin
          s.pad_address       = ALL_ONES_ADDR;
          s.protocol_version  = 8'hFF;
          s.control_type_code = 8'hFF;
          s.hello_type_code   = 8'hFE;
          s.peer_role_code    = 8'hFF;
          s.link_timeout_ms   = 16'hFFFF;
          s.telemetry_divider = 8'hFF;
        end
        2: begin
          // zero timeout and divider; hello code shadowed by the control code
          s.hello_type_code   = s.control_type_code;
          s.link_timeout_ms   = 16'd0;
          s.telemetry_divider = 8'd0;
        end
        default: begin
        end
      endcase
      put_reg(CFG_PAD_ADDRESS, s.pad_address, ADDR_W);
      put_reg(CFG_PROTO_VER, s.protocol_version, BYTE_W);
      put_reg(CFG_CTRL_TYPE, s.control_type_code, BYTE_W);
      put_reg(CFG_HELLO_TYPE, s.hello_type_code, BYTE_W);
      put_reg(CFG_PEER_ROLE, s.peer_role_code, BYTE_W);
      put_reg(CFG_LINK_TIMEOUT, s.link_timeout_ms, TMO_W);
      put_reg(CFG_TELEM_DIV, s.telemetry_divider, BYTE_W);
      cfg_ch.valid <= 1'b0;
      settings_done++;

      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (idle_gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle_gap) @(posedge clk);
          end
        end
        it.cmd            = CMD_FRAME;
        it.sender_present = 1'b1;
        it.sender_address = s.pad_address;
        it.frame_length   = byte_t'($urandom);
        it.type_byte      = byte_t'($urandom);
        it.version_byte   = byte_t'($urandom);
        it.role_byte      = byte_t'($urandom);
        r = $urandom_range(0, 99);
        // mostly well-formed link traffic, the rest is noise
        if (r < 35) begin
          it.cmd = CMD_TICK;
        end else if (r < 50) begin
          it.cmd = CMD_STEP;
        end else if (r < 65) begin
          it.type_byte    = s.control_type_code;
          it.frame_length = byte_t'(CONTROL_LEN);
        end else if (r < 72) begin
          it.type_byte    = s.hello_type_code;
          it.frame_length = byte_t'(HELLO_LEN);
          it.role_byte    = s.peer_role_code;
          if ($urandom_range(0, 3) != 0)
            it.version_byte = s.protocol_version;
        end else if (r < 78) begin
          it.sender_address = addr_t'({$urandom, $urandom});
          if (it.sender_address == s.pad_address)
            it.sender_address[0] = ~it.sender_address[0];
        end else if (r < 82) begin
          it.sender_present = 1'b0;
          it.sender_address = addr_t'({$urandom, $urandom});
        end else if (r < 86) begin
          it.type_byte = s.control_type_code;
        end else if (r < 90) begin
          it.type_byte    = s.hello_type_code;
          it.frame_length = byte_t'($urandom_range(0, 12));
          if ($urandom_range(0, 1) != 0)
            it.role_byte = s.peer_role_code;
        end else if (r < 94) begin
          // random type and length as drawn
        end else if (r < 97) begin
          it.frame_length = 8'd0;
        end else begin
          it.cmd = CMD_UNUSED;
        end
        send_item(it, 1'b0, '0);
        burst_left--;
      end
      in_ch.valid <= 1'b0;
    end

    settle();
    $display("covered %0d transactions (%0d from the table), %0d results checked",
             items_in, dir_rows.size(), results_out);
    $display("%0d register settings; %0d drive cuts, %0d restores, %0d captures, %0d wakes",
             settings_done, cuts_seen, restores_seen, captures_seen, wakes_seen);
    if (mismatches == 0) begin
      $display("link_frame_filter_failsafe_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("link_frame_filter_failsafe_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lffs_pkg.sv
hw/rtl/lffs_if.sv
hw/rtl/lffs_cfg.sv
hw/rtl/lffs_front.sv
hw/rtl/lffs_queue.sv
hw/rtl/lffs_back.sv
hw/rtl/link_frame_filter_failsafe_unit.sv
sim/link_frame_filter_failsafe_unit_tb.sv
